FILE: sv/knnk_pkg.sv
// knnk_pkg: shared types, widths and register codes for the k-nearest-neighbor block.
// No dependencies; imported by knnk_cell and knn_top_k_l2_select.
package knnk_pkg;

    // Fixed field widths of the result item and config port
    localparam int DIST_W     = 48;
    localparam int IDX_W      = 16;
    localparam int RANK_W     = 6;
    localparam int KCFG_W     = 7;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 2;

    localparam logic [DIST_W-1:0]  DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [KCFG_W-1:0]  K_RESET    = 7'd10;
    localparam logic [PADDR_W-1:0] REG_K_ADDR = 2'd0;

    // One slot of the sorted neighbor list
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } entry_t;

    localparam entry_t ENTRY_NONE = '{valid: 1'b0, distance: '0, idx: '0};

    // Command broadcast to every cell of the list
    typedef struct packed {
        logic              ins;
        logic              shift;
        logic              clr;
        logic [DIST_W-1:0] key_dist;
        logic [IDX_W-1:0]  key_idx;
    } cell_cmd_t;

    // Ordering by (distance, index): true when a goes ahead of b
    function automatic logic goes_before(input logic [DIST_W-1:0] a_dist,
                                         input logic [IDX_W-1:0]  a_idx,
                                         input logic [DIST_W-1:0] b_dist,
                                         input logic [IDX_W-1:0]  b_idx);
        return (a_dist < b_dist) || ((a_dist == b_dist) && (a_idx < b_idx));
    endfunction

endpackage

FILE: sv/knnk_ram.sv
// knnk_ram: generic single-port RAM with registered read data.
// No dependencies.
module knnk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write-first is not needed: read data captured during a write is never used
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/knnk_cell.sv
// knnk_cell: one slot of the systolic sorted top-k list.
// Depends on knnk_pkg (entry_t, cell_cmd_t, goes_before).
module knnk_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  knnk_pkg::cell_cmd_t cmd,
    input  knnk_pkg::entry_t    prev_entry,
    input  logic                prev_keep,
    input  knnk_pkg::entry_t    next_entry,
    output knnk_pkg::entry_t    entry,
    output logic                keep
);
    import knnk_pkg::*;

    logic              valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Slot holds its entry when it is valid and the new key does not go ahead of it
    assign keep = valid_reg && !goes_before(cmd.key_dist, cmd.key_idx, dist_reg, idx_reg);

    // Valid flag: control state, cleared by reset and by the end-of-set clear
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr) begin
            valid_reg <= 1'b0;
        end else if (cmd.ins && !keep) begin
            valid_reg <= prev_keep ? 1'b1 : prev_entry.valid;
        end else if (cmd.shift) begin
            valid_reg <= next_entry.valid;
        end
    end

    // Payload: insert the key here, take the upper neighbor, or shift toward the head
    always_ff @(posedge aclk) begin
        if (cmd.ins && !keep) begin
            if (prev_keep) begin
                dist_reg <= cmd.key_dist;
                idx_reg  <= cmd.key_idx;
            end else begin
                dist_reg <= prev_entry.distance;
                idx_reg  <= prev_entry.idx;
            end
        end else if (cmd.shift) begin
            dist_reg <= next_entry.distance;
            idx_reg  <= next_entry.idx;
        end
    end

    assign entry = '{valid: valid_reg, distance: dist_reg, idx: idx_reg};

endmodule

FILE: sv/knn_top_k_l2_select.sv
// Brute-force k-nearest-neighbor search (squared L2) with a systolic top-k list.
// Query coordinate: written to the query RAM. Database coordinate: query RAM read, square, accumulate,
// plus an insert of the vector into the cell chain when it ends the vector.
// End of set then streams min(k, count) results, one per cycle while m_ready is high.
// aresetn (synchronous) clears counters, accumulator, list valid bits and sets k to 10;
// the query RAM is not cleared. Depends on knnk_pkg, knnk_ram, knnk_cell.
module knn_top_k_l2_select #(
    parameter int MAX_DIMS   = 1024,
    parameter int TOP_K      = 64,
    parameter int MAX_POINTS = 65536,
    parameter int COORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [knnk_pkg::PADDR_W-1:0]        paddr,
    input  logic [knnk_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [knnk_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [COORD_BITS-1:0]        s_coord,
    input  logic                                s_end_of_vector,
    input  logic                                s_end_of_set,
    // Result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [knnk_pkg::IDX_W-1:0]          m_neighbor_index,
    output logic [knnk_pkg::DIST_W-1:0]         m_neighbor_distance,
    output logic [knnk_pkg::RANK_W-1:0]         m_rank,
    output logic                                m_last_result
);
    import knnk_pkg::*;

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PNT_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(TOP_K + 1);
    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

    localparam logic [DIM_W-1:0]  DIM_LAST = DIM_W'(MAX_DIMS - 1);
    localparam logic [PNT_W-1:0]  PNT_LAST = PNT_W'(MAX_POINTS - 1);
    localparam logic [CNT_W-1:0]  TOPK_CNT = CNT_W'(TOP_K);
    localparam logic [KCFG_W-1:0] TOPK_K   = KCFG_W'(TOP_K);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_ACC  = 5'b00100,
        S_INS  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [KCFG_W-1:0]        k_reg;
    logic [DIM_W-1:0]         dim_cnt_reg, dim_cnt_next;
    logic [DIST_W-1:0]        acc_reg, acc_next;
    logic [PNT_W-1:0]         vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rank_reg, rank_next;
    logic signed [COORD_BITS-1:0] coord_reg;
    logic                     vec_end_reg;
    logic                     set_end_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         m_index_reg;
    logic [DIST_W-1:0]        m_dist_reg;
    logic [RANK_W-1:0]        m_rank_reg;
    logic                     m_last_reg;

    logic                     s_fire;
    logic                     item_end;
    logic                     cfg_wr;
    logic signed [COORD_BITS-1:0] q_rdata;
    logic signed [MAG_W-1:0]  diff;
    logic [MAG_W-1:0]         mag;
    logic [SUM_W-1:0]         sum;
    logic [KCFG_W-1:0]        k_eff;
    logic [CNT_W-1:0]         n_emit;
    logic [CNT_W-1:0]         rank_inc;
    logic                     out_load;
    logic                     emit_last;
    cell_cmd_t                cmd;
    entry_t                   cell_q [TOP_K];
    logic [TOP_K-1:0]         keep_vec;
    logic [TOP_K-1:0]         valid_vec;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_K_ADDR);
    assign prdata = (paddr == REG_K_ADDR) ? {{(APB_DATA_W - KCFG_W){1'b0}}, k_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
        end else if (cfg_wr) begin
            k_reg <= pwdata[KCFG_W-1:0];
        end
    end

    // Input handshake: one item at a time
    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign item_end = s_mode ? (s_end_of_vector || s_end_of_set) : s_end_of_vector;

    // Query store, written by query items, read by database items
    knnk_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_DIMS)
    ) u_query_ram (
        .aclk  (aclk),
        .we    (s_fire && !s_mode),
        .addr  (dim_cnt_reg),
        .wdata (s_coord),
        .rdata (q_rdata)
    );

    // Difference magnitude and square
    assign diff = MAG_W'(coord_reg) - MAG_W'(q_rdata);
    assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    // Saturating accumulate
    assign sum = SUM_W'(acc_reg) + SUM_W'(sq_reg);

    // Emission count: min(clamped k, list fill)
    always_comb begin
        if (k_reg == '0) begin
            k_eff = KCFG_W'(1);
        end else if (k_reg > TOPK_K) begin
            k_eff = TOPK_K;
        end else begin
            k_eff = k_reg;
        end
    end

    assign n_emit    = (KCFG_W'(count_reg) < k_eff) ? count_reg : CNT_W'(k_eff);
    assign rank_inc  = rank_reg + CNT_W'(1);
    assign out_load  = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign emit_last = (rank_inc == n_emit);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        dim_cnt_next = dim_cnt_reg;
        acc_next     = acc_reg;
        vcnt_next    = vcnt_reg;
        count_next   = count_reg;
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg;
        cmd          = '{ins: 1'b0, shift: 1'b0, clr: 1'b0,
                         key_dist: acc_reg, key_idx: IDX_W'(vcnt_reg)};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (item_end || dim_cnt_reg == DIM_LAST) begin
                        dim_cnt_next = '0;
                    end else begin
                        dim_cnt_next = dim_cnt_reg + DIM_W'(1);
                    end
                    if (s_mode) begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_ACC;
            end
            S_ACC: begin
                acc_next   = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
                state_next = vec_end_reg ? S_INS : S_IDLE;
            end
            S_INS: begin
                cmd.ins  = 1'b1;
                acc_next = '0;
                if (count_reg != TOPK_CNT) begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (set_end_reg || vcnt_reg == PNT_LAST) begin
                    vcnt_next = '0;
                end else begin
                    vcnt_next = vcnt_reg + PNT_W'(1);
                end
                state_next = set_end_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (emit_last) begin
                        cmd.clr    = 1'b1;
                        count_next = '0;
                        rank_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        cmd.shift = 1'b1;
                        rank_next = rank_inc;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            dim_cnt_reg <= '0;
            acc_reg     <= '0;
            vcnt_reg    <= '0;
            count_reg   <= '0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dim_cnt_reg <= dim_cnt_next;
            acc_reg     <= acc_next;
            vcnt_reg    <= vcnt_next;
            count_reg   <= count_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers: captured item, square, result item
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            coord_reg   <= s_coord;
            vec_end_reg <= item_end;
            set_end_reg <= s_end_of_set;
        end
        if (state_reg == S_READ) begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
        if (out_load) begin
            m_index_reg <= cell_q[0].idx;
            m_dist_reg  <= cell_q[0].distance;
            m_rank_reg  <= RANK_W'(rank_reg);
            m_last_reg  <= emit_last;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_neighbor_index    = m_index_reg;
    assign m_neighbor_distance = m_dist_reg;
    assign m_rank              = m_rank_reg;
    assign m_last_result       = m_last_reg;

    // Sorted list: a row of cells, head at index 0
    for (genvar j = 0; j < TOP_K; j++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_k;

        if (j == 0) begin : g_head
            assign prev_e = ENTRY_NONE;
            assign prev_k = 1'b1;
        end else begin : g_body
            assign prev_e = cell_q[j-1];
            assign prev_k = keep_vec[j-1];
        end

        if (j == TOP_K - 1) begin : g_tail
            assign next_e = ENTRY_NONE;
        end else begin : g_inner
            assign next_e = cell_q[j+1];
        end

        knnk_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .prev_keep  (prev_k),
            .next_entry (next_e),
            .entry      (cell_q[j]),
            .keep       (keep_vec[j])
        );

        assign valid_vec[j] = cell_q[j].valid;
    end

`ifndef SYNTHESIS
    // List fill never exceeds its depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= TOPK_CNT)
        else $error("list fill above depth");

    // Valid cells match the fill count; emission shifts entries out before the clear
    a_count_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EMIT) |-> ($countones(valid_vec) == 32'(count_reg)))
        else $error("cell valid bits disagree with fill count");

    // Insert into a list that is not full grows it by one
    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS && count_reg != TOPK_CNT)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    // Final result of a set empties the list
    a_emit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && emit_last) |=> (count_reg == '0 && valid_vec == '0))
        else $error("list not cleared after last result");
`endif

endmodule
